### design/gpsl_pkg.sv
`timescale 1ns / 1ps

package gpsl_pkg;

	// polynomial width used inside the datapath; ports stay at FIELD_W
	localparam int POLY_BITS = 64;
	localparam int FIELD_W   = 64;
	localparam int IDX_W     = $clog2(POLY_BITS);
	localparam int REG_IDX_W = 2;

	typedef logic [POLY_BITS-1:0] poly_t;
	typedef logic [IDX_W-1:0]     deg_t;
	typedef logic [FIELD_W-1:0]   field_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_A0 = REG_IDX_W'(0),
		REG_A1 = REG_IDX_W'(1),
		REG_B0 = REG_IDX_W'(2),
		REG_B1 = REG_IDX_W'(3)
	} reg_idx_t;

	localparam poly_t POLY_ZERO = poly_t'(0);
	localparam poly_t POLY_ONE  = poly_t'(1);
	localparam poly_t POLY_TOP  = poly_t'(1) << (POLY_BITS - 1);
	localparam deg_t  DEG_TOP   = deg_t'(POLY_BITS - 1);

	typedef struct packed {
		poly_t a0;
		poly_t a1;
		poly_t b0;
		poly_t b1;
	} basis_t;

	typedef struct packed {
		logic  start;
		poly_t t;
	} inv_req_t;

	typedef struct packed {
		logic  done;
		logic  ok;
		poly_t g;
	} inv_rsp_t;

endpackage

### design/gpsl_mulstep.sv
`timescale 1ns / 1ps

// One Horner step of a product modulo p: shift, fold back x^deg(p), add.
module gpsl_mulstep (
	input  gpsl_pkg::poly_t acc,
	input  logic            bit_in,
	input  gpsl_pkg::poly_t addend,
	input  gpsl_pkg::poly_t prime,
	input  gpsl_pkg::poly_t ptop,
	output gpsl_pkg::poly_t acc_next
);
	import gpsl_pkg::*;

	poly_t shifted;
	logic  fold;

	always_comb begin
		shifted  = {acc[POLY_BITS-2:0], 1'b0};
		fold     = |(shifted & ptop);
		acc_next = shifted ^ (fold ? prime : POLY_ZERO) ^ (bit_in ? addend : POLY_ZERO);
	end

endmodule

### design/gpsl_inv.sv
`timescale 1ns / 1ps

// Extended Euclid inverse modulo p, one shift-xor, swap or degree step per cycle.
module gpsl_inv (
	input  logic              clk,
	input  logic              arst_n,
	input  gpsl_pkg::inv_req_t req,
	input  gpsl_pkg::poly_t   prime,
	input  gpsl_pkg::deg_t    prime_deg,
	output gpsl_pkg::inv_rsp_t rsp
);
	import gpsl_pkg::*;

	typedef enum logic [2:0] {
		I_IDLE = 3'b001,
		I_CHK  = 3'b010,
		I_NORM = 3'b100
	} inv_state_t;

	inv_state_t state_q, state_d;
	logic       done_q, done_d, ok_q;
	poly_t      u_q, v_q, g1_q, g2_q;
	deg_t       du_q, dv_q, shamt;

	assign shamt = du_q - dv_q;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			I_IDLE: begin
				if (req.start) state_d = I_CHK;
			end
			I_CHK: begin
				if (u_q == POLY_ONE || u_q == POLY_ZERO) begin
					state_d = I_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = I_NORM;
				end
			end
			I_NORM: begin
				if (u_q[du_q] && du_q >= dv_q) state_d = I_CHK;
			end
			default: state_d = I_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			I_IDLE: begin
				if (req.start) begin
					u_q  <= req.t;
					v_q  <= prime;
					g1_q <= POLY_ONE;
					g2_q <= POLY_ZERO;
					du_q <= DEG_TOP;
					dv_q <= prime_deg;
				end
			end
			I_CHK: begin
				ok_q <= (u_q == POLY_ONE);
			end
			I_NORM: begin
				if (!u_q[du_q]) begin
					// tighten the degree bound of u
					du_q <= du_q - deg_t'(1);
				end else if (du_q < dv_q) begin
					u_q  <= v_q;
					v_q  <= u_q;
					g1_q <= g2_q;
					g2_q <= g1_q;
					du_q <= dv_q;
					dv_q <= du_q;
				end else begin
					u_q  <= u_q ^ (v_q << shamt);
					g1_q <= g1_q ^ (g2_q << shamt);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.ok   = ok_q;
	assign rsp.g    = g1_q;

endmodule

### design/gpsl_core.sv
`timescale 1ns / 1ps

// Sequencer: degree scan, bit-serial passes on the shared step unit, inverse.
module gpsl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gpsl_pkg::poly_t   prime_in,
	input  gpsl_pkg::poly_t   root_in,
	input  gpsl_pkg::basis_t  basis,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output gpsl_pkg::poly_t   res_poly,
	output logic              res_proj
);
	import gpsl_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SCAN = 8'b0000_0010,
		ST_REMX = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_REMY = 8'b0001_0000,
		ST_INV  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t   state_q, state_d;
	poly_t    p_q, r_q, ptop_q, s_q, add_q, acc_q, prod_q, res_q;
	deg_t     dp_q, cnt_q;
	logic     proj_q, above_q, phase1_q, res_proj_q;
	poly_t    step_acc, t_now, x_t0, x_t1, s_sel, y_sel;
	logic     hit, r_hit, proj_now, last;
	inv_req_t inv_req;
	inv_rsp_t inv_rsp;

	gpsl_mulstep u_step (
		.acc     (acc_q),
		.bit_in  (s_q[POLY_BITS-1]),
		.addend  (add_q),
		.prime   (p_q),
		.ptop    (ptop_q),
		.acc_next(step_acc)
	);

	gpsl_inv u_inv (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (inv_req),
		.prime    (p_q),
		.prime_deg(dp_q),
		.rsp      (inv_rsp)
	);

	always_comb begin
		hit      = |(p_q & ptop_q);
		r_hit    = |(r_q & ptop_q);
		proj_now = !above_q && r_hit;
		last     = (cnt_q == '0);
		t_now    = prod_q ^ step_acc;
		x_t0     = proj_now ? basis.a0 : basis.b0;
		x_t1     = proj_q ? basis.a1 : basis.b1;
		s_sel    = (!phase1_q && proj_q) ? (r_q ^ p_q) : r_q;
		if (phase1_q) y_sel = proj_q ? basis.b1 : basis.a1;
		else          y_sel = proj_q ? basis.b0 : basis.a0;
		inv_req.start = (state_q == ST_REMY) && last && !phase1_q && (t_now != POLY_ZERO);
		inv_req.t     = t_now;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = (prime_in[POLY_BITS-1:1] == '0) ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: if (hit) state_d = ST_REMX;
			ST_REMX: if (last) state_d = ST_MUL;
			ST_MUL:  if (last) state_d = ST_REMY;
			ST_REMY: begin
				if (last) begin
					if (phase1_q)                  state_d = ST_FIN;
					else if (t_now == POLY_ZERO)   state_d = ST_DONE;
					else                           state_d = ST_INV;
				end
			end
			ST_INV: begin
				if (inv_rsp.done) state_d = inv_rsp.ok ? ST_REMX : ST_DONE;
			end
			ST_FIN:  if (last) state_d = ST_DONE;
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (start) begin
					p_q        <= prime_in;
					r_q        <= root_in;
					ptop_q     <= POLY_TOP;
					cnt_q      <= DEG_TOP;
					above_q    <= 1'b0;
					phase1_q   <= 1'b0;
					res_q      <= prime_in;
					res_proj_q <= 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					dp_q   <= cnt_q;
					proj_q <= proj_now;
					s_q    <= x_t0;
					add_q  <= POLY_ONE;
					acc_q  <= POLY_ZERO;
					cnt_q  <= DEG_TOP;
				end else begin
					above_q <= above_q | r_hit;
					ptop_q  <= ptop_q >> 1;
					cnt_q   <= cnt_q - deg_t'(1);
				end
			end
			ST_REMX, ST_MUL, ST_REMY, ST_FIN: begin
				if (!last) begin
					acc_q <= step_acc;
					s_q   <= s_q << 1;
					cnt_q <= cnt_q - deg_t'(1);
				end else begin
					acc_q <= POLY_ZERO;
					cnt_q <= DEG_TOP;
					if (state_q == ST_REMX) begin
						add_q <= step_acc;
						s_q   <= s_sel;
					end else if (state_q == ST_MUL) begin
						prod_q <= step_acc;
						add_q  <= POLY_ONE;
						s_q    <= y_sel;
					end else if (state_q == ST_REMY) begin
						// t1 is ready: multiply it by the inverse
						add_q <= t_now;
						s_q   <= inv_rsp.g;
					end else begin
						res_q      <= step_acc;
						res_proj_q <= 1'b0;
					end
				end
			end
			ST_INV: begin
				if (inv_rsp.done && inv_rsp.ok) begin
					phase1_q <= 1'b1;
					s_q      <= x_t1;
					add_q    <= POLY_ONE;
					acc_q    <= POLY_ZERO;
					cnt_q    <= DEG_TOP;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_poly  = res_q;
	assign res_proj  = res_proj_q;

endmodule

### design/gf2_poly_sieve_lambda_top.sv
`timescale 1ns / 1ps
// Path: a zero or one p goes straight to the result, projective; when t0 is zero the scan and
// the first three passes run and p comes back projective; on the full path the inverse and
// four more passes follow; a failed inverse ends with p projective as well.
// Throughput: one request at a time, the next taken in the cycle after the last result is loaded
// into the output register; a full item takes seven passes on the shared step unit plus the inverse.
// Reset: arst_n asynchronous, active low; clears control and the four basis registers to zero.
module gf2_poly_sieve_lambda_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  gpsl_pkg::field_t       prime_poly,
	input  gpsl_pkg::field_t       root_poly,
	output logic                   out_valid,
	input  logic                   out_ready,
	output gpsl_pkg::field_t       lambda_poly,
	output logic                   is_projective,
	input  logic                   wr_en,
	input  logic [gpsl_pkg::REG_IDX_W-1:0] wr_index,
	input  gpsl_pkg::field_t       wr_data
);
	import gpsl_pkg::*;

	basis_t basis_q;
	logic   core_idle, res_valid, res_ready, res_proj, start;
	poly_t  res_poly;

	// result register: lets the core take the next request while a result waits
	logic   out_valid_q, out_proj_q;
	poly_t  out_poly_q;

	// basis registers; only the low POLY_BITS bits are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_A0: basis_q.a0 <= wr_data[POLY_BITS-1:0];
				REG_A1: basis_q.a1 <= wr_data[POLY_BITS-1:0];
				REG_B0: basis_q.b0 <= wr_data[POLY_BITS-1:0];
				REG_B1: basis_q.b1 <= wr_data[POLY_BITS-1:0];
				default: ;
			endcase
		end
	end

	// accept a request only while the sequencer is idle
	assign in_ready = core_idle;
	assign start    = in_valid && core_idle;

	gpsl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.prime_in (prime_poly[POLY_BITS-1:0]),
		.root_in  (root_poly[POLY_BITS-1:0]),
		.basis    (basis_q),
		.idle     (core_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_poly (res_poly),
		.res_proj (res_proj)
	);

	// advance a finished result when the output register is empty or draining
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_poly_q <= res_poly;
			out_proj_q <= res_proj;
		end
	end

	assign out_valid     = out_valid_q;
	assign lambda_poly   = field_t'(out_poly_q);
	assign is_projective = out_proj_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import gpsl_pkg::*;

	// Cycles the block may still need after its last result; also the tail at the end.
	localparam int SETTLE_CYCLES = 1000;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int RANDOM_PHASES = 6;

	// Only the low POLY_BITS bits of every polynomial take part.
	localparam field_t POLY_MASK = (POLY_BITS >= FIELD_W) ? '1
		: ((field_t'(1) << POLY_BITS) - field_t'(1));

	// A few irreducible polynomials, against which every nonzero t0 has an inverse.
	localparam field_t IRRED_X1   = 64'h3;
	localparam field_t IRRED_X2   = 64'h7;
	localparam field_t IRRED_X3   = 64'hB;
	localparam field_t IRRED_X4   = 64'h13;
	localparam field_t IRRED_X5   = 64'h25;
	localparam field_t IRRED_X7   = 64'h83;
	localparam field_t IRRED_X8   = 64'h11B;
	localparam field_t IRRED_X31  = 64'h8000_0009;
	localparam field_t IRRED_X63  = 64'h8000_0000_0000_0003;

	typedef struct packed {
		field_t prime;
		field_t root;
		field_t lambda;
		logic   proj;
	} lambda_entry_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	field_t prime_poly;
	field_t root_poly;
	logic   out_valid;
	logic   out_ready;
	field_t lambda_poly;
	logic   is_projective;
	logic   wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	field_t wr_data;

	// Own copy of the lattice basis, updated on every register write.
	basis_t lattice;

	lambda_entry_t pending_lambdas[$];
	int requests_sent;
	int lambdas_seen;
	int projective_seen;
	int mismatch_count;

	gf2_poly_sieve_lambda_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.prime_poly    (prime_poly),
		.root_poly     (root_poly),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.lambda_poly   (lambda_poly),
		.is_projective (is_projective),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// GF(2)[x] arithmetic for the predictor
	// ---------------------------------------------------------------

	// Degree of a polynomial; -1 for the zero polynomial.
	function automatic int gf2_degree(field_t a);
		int d = -1;
		for (int i = 0; i < FIELD_W; i++)
			if (a[i])
				d = i;
		return d;
	endfunction

	// a mod p; p must be nonzero.
	function automatic field_t gf2_reduce(field_t a, field_t p);
		int d = gf2_degree(p);
		for (int i = FIELD_W - 1; i >= d; i--)
			if (a[i])
				a ^= p << (i - d);
		return a;
	endfunction

	// (a * b) mod p, shift-and-add from the top bit of b down.
	function automatic field_t gf2_mul_reduce(field_t a, field_t b, field_t p);
		int     d = gf2_degree(p);
		field_t acc = '0;
		a = gf2_reduce(a, p);
		b = gf2_reduce(b, p);
		for (int i = FIELD_W - 1; i >= 0; i--) begin
			acc = acc << 1;
			if (acc[d])
				acc ^= p;
			if (b[i])
				acc ^= a;
		end
		return acc;
	endfunction

	// Inverse of t mod p by the polynomial extended Euclid; 0 when gcd(t, p) != 1.
	function automatic bit gf2_inverse(field_t t, field_t p, output field_t inv);
		field_t u = gf2_reduce(t, p);
		field_t v = p;
		field_t g1 = field_t'(1);
		field_t g2 = '0;
		field_t swap;
		int     shift;
		inv = '0;
		while (u != field_t'(1)) begin
			if (u == '0)
				return 1'b0;
			shift = gf2_degree(u) - gf2_degree(v);
			if (shift < 0) begin
				swap = u; u = v; v = swap;
				swap = g1; g1 = g2; g2 = swap;
				shift = -shift;
			end
			u ^= v << shift;
			g1 ^= g2 << shift;
		end
		inv = gf2_reduce(g1, p);
		return 1'b1;
	endfunction

	// Expected lambda and projective flag for one (p, r) under the current basis.
	function automatic lambda_entry_t predict_lambda(field_t prime_in, field_t root_in);
		lambda_entry_t e;
		field_t p = prime_in & POLY_MASK;
		field_t r = root_in & POLY_MASK;
		field_t t0;
		field_t t1;
		field_t inv;
		bit     at_infinity;
		e.prime  = prime_in;
		e.root   = root_in;
		e.lambda = p;
		e.proj   = 1'b1;
		if (p == '0)
			return e;
		at_infinity = (gf2_degree(r) == gf2_degree(p));
		if (at_infinity)
			t0 = gf2_reduce(gf2_mul_reduce(lattice.a0, r ^ p, p) ^ lattice.b0, p);
		else
			t0 = gf2_reduce(lattice.a0 ^ gf2_mul_reduce(lattice.b0, r, p), p);
		if (t0 == '0 || !gf2_inverse(t0, p, inv))
			return e;
		if (at_infinity)
			t1 = gf2_reduce(lattice.b1 ^ gf2_mul_reduce(lattice.a1, r, p), p);
		else
			t1 = gf2_reduce(gf2_mul_reduce(lattice.b1, r, p) ^ lattice.a1, p);
		e.lambda = gf2_mul_reduce(inv, t1, p) & POLY_MASK;
		e.proj   = 1'b0;
		return e;
	endfunction

	// ---------------------------------------------------------------
	// Random helpers
	// ---------------------------------------------------------------

	function automatic field_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Prime: mostly irreducible or a random polynomial of random degree,
	// sometimes the degenerate zero and one, sometimes full-width words.
	function automatic field_t rand_prime();
		int     roll = $urandom_range(0, 99);
		int     d;
		field_t p;
		if (roll < 30) begin
			case ($urandom_range(0, 8))
				0: p = IRRED_X1;
				1: p = IRRED_X2;
				2: p = IRRED_X3;
				3: p = IRRED_X4;
				4: p = IRRED_X5;
				5: p = IRRED_X7;
				6: p = IRRED_X8;
				7: p = IRRED_X31;
				default: p = IRRED_X63;
			endcase
		end else if (roll < 85) begin
			d = $urandom_range(1, FIELD_W - 1);
			p = (rand_word() & ((field_t'(1) << d) - field_t'(1))) | (field_t'(1) << d);
		end else if (roll < 91) begin
			p = rand_word();
		end else if (roll < 95) begin
			p = field_t'($urandom_range(0, 1));
		end else begin
			p = ($urandom_range(0, 1) != 0) ? '1 : (field_t'(1) << (FIELD_W - 1));
		end
		return p;
	endfunction

	// Root: mostly below deg p, some of equal degree (projective), some too large.
	function automatic field_t rand_root(field_t p);
		int     roll = $urandom_range(0, 99);
		int     d = gf2_degree(p);
		field_t low_mask;
		if (d < 0)
			return rand_word();
		low_mask = (field_t'(1) << d) - field_t'(1);
		if (roll < 60)
			return rand_word() & low_mask;
		if (roll < 80)
			return (rand_word() & low_mask) | (field_t'(1) << d);
		if (roll < 90)
			return rand_word();
		return field_t'($urandom_range(0, 1));
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Send one request. On return the request has just been accepted and in_valid is
	// still high; the next call replaces it or takes it down, drain_lambdas takes it down.
	task automatic send_request(input field_t p, input field_t r);
		int gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		prime_poly <= p;
		root_poly  <= r;
		do @(posedge clk); while (!in_ready);
		pending_lambdas.push_back(predict_lambda(p, r));
		requests_sent++;
	endtask

	// Drop valid and hold until every expected lambda has come back.
	task automatic drain_lambdas();
		in_valid <= 1'b0;
		while (pending_lambdas.size() != 0)
			@(posedge clk);
	endtask

	// Write all four basis registers back to back; the block must be idle.
	task automatic load_basis(input field_t a0, input field_t a1,
			input field_t b0, input field_t b1);
		reg_idx_t idx;
		field_t   val;
		for (int i = 0; i < 4; i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_A0: begin val = a0; lattice.a0 = a0 & POLY_MASK; end
				REG_A1: begin val = a1; lattice.a1 = a1 & POLY_MASK; end
				REG_B0: begin val = b0; lattice.b0 = b0 & POLY_MASK; end
				default: begin val = b1; lattice.b1 = b1 & POLY_MASK; end
			endcase
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= val;
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Result side: random backpressure and the checker
	// ---------------------------------------------------------------

	initial begin : result_backpressure
		int run;
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			// now and then a long stretch with no stalls at all
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 2000)
				: $urandom_range(1, 40);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : lambda_checker
		lambda_entry_t exp_e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				lambdas_seen++;
				if (is_projective)
					projective_seen++;
				if (pending_lambdas.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("[%0t] unexpected result lambda=%h proj=%b", $realtime,
							lambda_poly, is_projective);
				end else begin
					exp_e = pending_lambdas.pop_front();
					if (lambda_poly !== exp_e.lambda || is_projective !== exp_e.proj) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("[%0t] p=%h r=%h: expected lambda=%h proj=%b, got lambda=%h proj=%b",
								$realtime, exp_e.prime, exp_e.root, exp_e.lambda,
								exp_e.proj, lambda_poly, is_projective);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Basis still at its reset value of zero: t0 is always zero, so every
	// request comes back projective, including the zero and constant primes.
	task automatic test_reset_basis();
		send_request(64'h0, 64'h0);
		send_request(64'h1, 64'h0);
		send_request(IRRED_X8, 64'h57);
		send_request(IRRED_X63, IRRED_X63 ^ 64'h2);
		drain_lambdas();
	endtask

	// Identity basis: the finite branch gives lambda = r mod p, so degree edges
	// and field extremes are easy to see.
	task automatic test_degree_edges();
		load_basis(64'h1, 64'h0, 64'h0, 64'h1);
		send_request(64'h0, 64'h0);                      // zero prime with zero root
		send_request(64'h0, '1);                         // zero prime
		send_request(64'h1, 64'h0);                      // constant prime
		send_request(64'h2, 64'h1);                      // finite root, degree-one prime
		send_request(64'h2, 64'h3);                      // equal degree: projective branch
		send_request(IRRED_X1, 64'h2);
		send_request('1, '1);                            // all ones on both fields
		send_request(IRRED_X63, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(IRRED_X8, '1);                      // root too large, reduced mod p
		send_request(IRRED_X8, 64'h80);
		send_request(field_t'(1) << (FIELD_W - 1), 64'h1);
		drain_lambdas();
	endtask

	// t0 = r mod p here, so a reducible prime sharing a factor with r has no inverse.
	task automatic test_reducible_prime();
		load_basis(64'h0, '1, 64'h1, 64'h0);
		send_request(64'h5, 64'h3);                      // gcd(x+1, x^2+1) = x+1
		send_request(64'h5, 64'h0);                      // t0 zero
		send_request(64'h5, 64'h2);                      // invertible despite reducible p
		send_request(64'hF, 64'h5);                      // (x+1)^2 against (x+1)^3
		drain_lambdas();
	endtask

	// Random requests over several bases, extremes included; in each phase the
	// sender holds off once until every outstanding lambda has returned.
	task automatic test_random_bases();
		field_t p;
		int     hold_at;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: load_basis('1, '1, '1, '1);
				1: load_basis(field_t'(1) << (FIELD_W - 1), 64'h1,
					64'h1, field_t'(1) << (FIELD_W - 1));
				2: load_basis(rand_word(), 64'h0, rand_word(), 64'h0);
				default: load_basis(rand_word(), rand_word(), rand_word(), rand_word());
			endcase
			hold_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == hold_at)
					drain_lambdas();
				p = rand_prime();
				send_request(p, rand_root(p));
			end
			drain_lambdas();
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin : main_sequence
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		prime_poly <= '0;
		root_poly  <= '0;
		wr_en      <= 1'b0;
		wr_index   <= REG_A0;
		wr_data    <= '0;
		lattice    = '0;
		requests_sent   = 0;
		lambdas_seen    = 0;
		projective_seen = 0;
		mismatch_count  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_basis();
		test_degree_edges();
		test_reducible_prime();
		test_random_bases();

		drain_lambdas();
		repeat (SETTLE_CYCLES) @(posedge clk);
		// anything still queued was never answered
		if (pending_lambdas.size() != 0) begin
			mismatch_count += pending_lambdas.size();
			$display("%0d expected lambdas never arrived", pending_lambdas.size());
		end

		$display("Sent %0d requests over %0d basis settings; %0d lambdas checked, %0d projective.",
			requests_sent, RANDOM_PHASES + 3, lambdas_seen, projective_seen);
		$display("Mismatches counted: %0d.", mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin : watchdog
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
